### src/sfds_pkg.sv
package sfds_pkg;

  // Header markers and check values.
  localparam logic [7:0] MK_FREE      = 8'h7A;
  localparam logic [7:0] MK_HEAD      = 8'h18;
  localparam logic [7:0] MK_CONT      = 8'h1A;
  localparam logic [7:0] HEAD_CHECK_A = 8'h00;
  localparam logic [7:0] HEAD_CHECK_B = 8'h10;

  localparam int unsigned DIV_W       = 32;
  localparam int unsigned DIV_STEP_W  = 5;
  localparam logic [DIV_W-1:0] NS_PER_SEC = 32'd1000000000;

  localparam int unsigned RATE_W      = 30;
  localparam int unsigned TOTAL_W     = 13;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  // Result kind. The front uses the same codes to classify a request before
  // the head-seen lookup; KIND_HEAD there means a head candidate.
  typedef enum logic [1:0] {
    KIND_FREE   = 2'd0,
    KIND_HEAD   = 2'd1,
    KIND_CONT   = 2'd2,
    KIND_IGNORE = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       cls;
    logic        in_range;
    logic [7:0]  slot;
    logic [31:0] period;
    logic [31:0] frames;
  } item_t;

endpackage

### src/sfds_front.sv
module sfds_front #(
  parameter int unsigned SLOT_COUNT = 64
) (
  input  logic [7:0]     marker_i,
  input  logic [7:0]     slot_byte_i,
  input  logic [7:0]     check_a_i,
  input  logic [7:0]     check_b_i,
  input  logic [31:0]    period_raw_i,
  input  logic [31:0]    frames_raw_i,
  output sfds_pkg::item_t item_o
);
  import sfds_pkg::*;

  logic in_range;
  logic checks_ok;

  assign in_range  = {1'b0, slot_byte_i} < 9'(SLOT_COUNT);
  assign checks_ok = (check_a_i == HEAD_CHECK_A) && (check_b_i == HEAD_CHECK_B);

  always_comb begin
    item_o.in_range = in_range;
    item_o.slot     = slot_byte_i;
    // Both words arrive with their 16-bit halves swapped.
    item_o.period   = {period_raw_i[15:0], period_raw_i[31:16]};
    item_o.frames   = {frames_raw_i[15:0], frames_raw_i[31:16]};
    priority if (marker_i == MK_FREE) begin
      item_o.cls = KIND_FREE;
    end else if (in_range && marker_i == MK_HEAD && checks_ok) begin
      item_o.cls = KIND_HEAD;
    end else if (in_range && marker_i == MK_CONT) begin
      item_o.cls = KIND_CONT;
    end else begin
      item_o.cls = KIND_IGNORE;
    end
  end

endmodule

### src/sfds_fifo.sv
module sfds_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sfds_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output sfds_pkg::item_t item_o
);
  import sfds_pkg::*;

  item_t             entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign full_o  = count_q == QCNT_W'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign item_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

### src/sfds_div.sv
module sfds_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quotient_o
);
  import sfds_pkg::*;

  logic                  busy_q;
  logic                  done_q;
  logic [DIV_STEP_W-1:0] step_q;
  logic [DIV_W-1:0]      rem_q, rem_d;
  logic [DIV_W-1:0]      quo_q, quo_d;
  logic [DIV_W-1:0]      dvs_q;
  logic [DIV_W:0]        rem_shift;
  logic [DIV_W+1:0]      diff;
  logic                  fits;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    rem_shift = {rem_q, quo_q[DIV_W-1]};
    diff      = {1'b0, rem_shift} - {2'b00, dvs_q};
    fits      = !diff[DIV_W+1];
    rem_d     = fits ? diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
    quo_d     = {quo_q[DIV_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == DIV_STEP_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### src/sfds_back.sv
module sfds_back #(
  parameter int unsigned SLOT_COUNT  = 64,
  parameter int unsigned MAX_SECTORS = 4096
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  sfds_pkg::item_t item_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      slot_out_o,
  output logic [29:0]     sample_rate_o,
  output logic [31:0]     frame_count_o,
  output logic [12:0]     slot_sector_total_o,
  output logic [12:0]     free_total_o
);
  import sfds_pkg::*;

  localparam int unsigned SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_SECTORS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SECTORS);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_READ   = 5'b00010,
    ST_UPDATE = 5'b00100,
    ST_DIVIDE = 5'b01000,
    ST_DONE   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  item_t  cur_q;

  logic [CNT_W-1:0]      cnt_mem [SLOT_COUNT];
  logic [CNT_W-1:0]      rd_q;
  logic [SLOT_COUNT-1:0] cnt_vld_q;
  logic [SLOT_COUNT-1:0] seen_q;
  logic [CNT_W-1:0]      free_q;

  kind_e              res_kind_q;
  logic [CNT_W-1:0]   res_total_q;
  logic [RATE_W-1:0]  res_rate_q;
  logic [31:0]        res_frames_q;

  logic               out_valid_q;
  kind_e              out_kind_q;
  logic [7:0]         out_slot_q;
  logic [RATE_W-1:0]  out_rate_q;
  logic [31:0]        out_frames_q;
  logic [CNT_W-1:0]   out_total_q;
  logic [CNT_W-1:0]   out_free_q;

  logic [SLOT_W-1:0]  idx;
  logic [CNT_W-1:0]   cnt_cur;
  logic [CNT_W-1:0]   cnt_inc;
  logic [CNT_W-1:0]   free_inc;
  logic               head_ok;
  logic               cnt_we;
  logic               div_start;
  logic               div_done;
  logic [31:0]        div_quo;
  logic [31:0]        dividend;
  logic               out_load;
  logic [CNT_W+12:0]  total_ext;
  logic [CNT_W+12:0]  free_ext;

  assign idx      = cur_q.slot[SLOT_W-1:0];
  assign cnt_cur  = cnt_vld_q[idx] ? rd_q : '0;
  assign cnt_inc  = (cnt_cur < CNT_MAX) ? cnt_cur + 1'b1 : CNT_MAX;
  assign free_inc = (free_q < CNT_MAX) ? free_q + 1'b1 : CNT_MAX;
  assign head_ok  = (cur_q.cls == KIND_HEAD) && !seen_q[idx];
  assign cnt_we   = (state_q == ST_UPDATE) && (head_ok || cur_q.cls == KIND_CONT);
  assign div_start = (state_q == ST_UPDATE) && head_ok && (cur_q.period != '0);
  // Rounded half up; the sum stays below 2^32 for any period.
  assign dividend = NS_PER_SEC + {1'b0, cur_q.period[31:1]};
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign pop_o    = (state_q == ST_IDLE) && !empty_i;

  sfds_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (cur_q.period),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (!empty_i) state_d = ST_READ;
      ST_READ:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = div_start ? ST_DIVIDE : ST_DONE;
      ST_DIVIDE: if (div_done) state_d = ST_DONE;
      ST_DONE:   if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_vld_q   <= '0;
      seen_q      <= '0;
      free_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cnt_we) begin
        cnt_vld_q[idx] <= 1'b1;
      end
      if ((state_q == ST_UPDATE) && head_ok) begin
        seen_q[idx] <= 1'b1;
      end
      if ((state_q == ST_UPDATE) && (cur_q.cls == KIND_FREE)) begin
        free_q <= free_inc;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Slot counter memory: one read and one write port, read data registered.
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[idx] <= cnt_inc;
    end
    if (state_q == ST_READ) begin
      rd_q <= cnt_mem[idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= item_i;
    end
    if (state_q == ST_UPDATE) begin
      res_rate_q <= '0;
      if (cur_q.cls == KIND_FREE) begin
        res_kind_q   <= KIND_FREE;
        res_frames_q <= '0;
      end else if (head_ok) begin
        res_kind_q   <= KIND_HEAD;
        res_frames_q <= cur_q.frames;
      end else if (cur_q.cls == KIND_CONT) begin
        res_kind_q   <= KIND_CONT;
        res_frames_q <= '0;
      end else begin
        res_kind_q   <= KIND_IGNORE;
        res_frames_q <= '0;
      end
      if (!cur_q.in_range) begin
        res_total_q <= '0;
      end else if (cnt_we) begin
        res_total_q <= cnt_inc;
      end else begin
        res_total_q <= cnt_cur;
      end
    end
    if ((state_q == ST_DIVIDE) && div_done) begin
      res_rate_q <= div_quo[RATE_W-1:0];
    end
    if (out_load) begin
      out_kind_q   <= res_kind_q;
      out_slot_q   <= cur_q.slot;
      out_rate_q   <= res_rate_q;
      out_frames_q <= res_frames_q;
      out_total_q  <= res_total_q;
      out_free_q   <= free_q;
    end
  end

  assign total_ext = {13'b0, out_total_q};
  assign free_ext  = {13'b0, out_free_q};

  assign out_valid_o         = out_valid_q;
  assign kind_o              = out_kind_q;
  assign slot_out_o          = out_slot_q;
  assign sample_rate_o       = out_rate_q;
  assign frame_count_o       = out_frames_q;
  assign slot_sector_total_o = total_ext[12:0];
  assign free_total_o        = free_ext[12:0];

endmodule

### src/sample_flash_directory_scan_top.sv
// Each accepted request passes through the queue and the back-end sequencer states
// READ, UPDATE and DONE; a head sector with a nonzero period also passes through
// DIVIDE, which runs the 32-step iterative divider. The back-end sequencer handles
// one request at a time and takes no new one until the last result is loaded.
// A two-entry queue lets the front take requests while the back end is busy.
// Reset (rst_ni low, asynchronous) clears all counts and head flags at once.
module sample_flash_directory_scan_top #(
  parameter int unsigned SLOT_COUNT  = 64,
  parameter int unsigned MAX_SECTORS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  marker_i,
  input  logic [7:0]  slot_byte_i,
  input  logic [7:0]  check_a_i,
  input  logic [7:0]  check_b_i,
  input  logic [31:0] period_raw_i,
  input  logic [31:0] frames_raw_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  slot_out_o,
  output logic [29:0] sample_rate_o,
  output logic [31:0] frame_count_o,
  output logic [12:0] slot_sector_total_o,
  output logic [12:0] free_total_o
);
  import sfds_pkg::*;

  item_t front_item;
  item_t queue_item;
  logic  queue_full;
  logic  queue_empty;
  logic  queue_pop;
  logic  push;

  assign in_stall_o = queue_full;
  assign push       = in_valid_i && !queue_full;

  sfds_front #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_front (
    .marker_i     (marker_i),
    .slot_byte_i  (slot_byte_i),
    .check_a_i    (check_a_i),
    .check_b_i    (check_b_i),
    .period_raw_i (period_raw_i),
    .frames_raw_i (frames_raw_i),
    .item_o       (front_item)
  );

  sfds_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .empty_o (queue_empty),
    .item_o  (queue_item)
  );

  sfds_back #(
    .SLOT_COUNT  (SLOT_COUNT),
    .MAX_SECTORS (MAX_SECTORS)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .empty_i             (queue_empty),
    .item_i              (queue_item),
    .pop_o               (queue_pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .kind_o              (kind_o),
    .slot_out_o          (slot_out_o),
    .sample_rate_o       (sample_rate_o),
    .frame_count_o       (frame_count_o),
    .slot_sector_total_o (slot_sector_total_o),
    .free_total_o        (free_total_o)
  );

endmodule

### src/sfds_checker.sv
module sfds_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  kind_o,
  input logic [7:0]  slot_out_o,
  input logic [29:0] sample_rate_o,
  input logic [31:0] frame_count_o,
  input logic [12:0] slot_sector_total_o
);
  import sfds_pkg::*;

  // A stalled result holds its fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
      $stable(slot_out_o) && $stable(sample_rate_o) && $stable(frame_count_o))
    else $error("stalled result changed");

  // Only an accepted head carries a rate or a frame count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != KIND_HEAD) |-> sample_rate_o == '0 && frame_count_o == '0)
    else $error("rate or frames on a non-head result");

  // Heads and continuations always count a sector for their slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_HEAD || kind_o == KIND_CONT) |->
      slot_sector_total_o != '0)
    else $error("counted sector shows a zero total");

  // The rate can never exceed one sample per nanosecond.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sample_rate_o <= 30'd1000000000)
    else $error("sample rate out of range");

endmodule

bind sample_flash_directory_scan_top sfds_checker u_sfds_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .kind_o              (kind_o),
  .slot_out_o          (slot_out_o),
  .sample_rate_o       (sample_rate_o),
  .frame_count_o       (frame_count_o),
  .slot_sector_total_o (slot_sector_total_o)
);

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import sfds_pkg::*;

  localparam int unsigned SLOT_N       = 64;
  localparam int unsigned MAX_SECT     = 4096;
  localparam int unsigned RANDOM_ITEMS = 650;
  localparam int unsigned TAIL_PAIRS   = 50;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam logic [63:0] NS_PER_SEC64 = 64'd1000000000;

  typedef struct packed {
    logic [7:0]  marker;
    logic [7:0]  slot;
    logic [7:0]  check_a;
    logic [7:0]  check_b;
    logic [31:0] period_raw;
    logic [31:0] frames_raw;
  } header_t;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         slot;
    logic [RATE_W-1:0]  rate;
    logic [31:0]        frames;
    logic [TOTAL_W-1:0] slot_total;
    logic [TOTAL_W-1:0] free_total;
  } entry_t;

  class dir_scan_scoreboard;
    bit                 slot_head_taken[SLOT_N];
    logic [TOTAL_W-1:0] slot_count[SLOT_N];
    logic [TOTAL_W-1:0] free_count;
    entry_t             expected_entries[$];
    int unsigned        errors;

    function new();
      foreach (slot_head_taken[i]) begin
        slot_head_taken[i] = 1'b0;
        slot_count[i]      = '0;
      end
      free_count = '0;
      errors     = 0;
    endfunction

    function logic [TOTAL_W-1:0] bump_count(logic [TOTAL_W-1:0] c);
      return (c < MAX_SECT) ? c + 1'b1 : TOTAL_W'(MAX_SECT);
    endfunction

    function void note_header(header_t h);
      entry_t      e;
      logic [31:0] period;
      logic [63:0] quot;
      bit          in_range;
      in_range = h.slot < SLOT_N;
      e.kind   = KIND_IGNORE;
      e.slot   = h.slot;
      e.rate   = '0;
      e.frames = '0;
      if (h.marker == MK_FREE) begin
        free_count = bump_count(free_count);
        e.kind = KIND_FREE;
      end else if (in_range) begin
        if (h.marker == MK_HEAD && h.check_a == HEAD_CHECK_A && h.check_b == HEAD_CHECK_B &&
            !slot_head_taken[h.slot]) begin
          // Both words arrive with their 16-bit halves swapped.
          period = {h.period_raw[15:0], h.period_raw[31:16]};
          slot_head_taken[h.slot] = 1'b1;
          if (period != 0) begin
            quot   = (NS_PER_SEC64 + {33'd0, period[31:1]}) / {32'd0, period};
            e.rate = quot[RATE_W-1:0];
          end
          e.frames = {h.frames_raw[15:0], h.frames_raw[31:16]};
          slot_count[h.slot] = bump_count(slot_count[h.slot]);
          e.kind = KIND_HEAD;
        end else if (h.marker == MK_CONT) begin
          slot_count[h.slot] = bump_count(slot_count[h.slot]);
          e.kind = KIND_CONT;
        end
      end
      e.slot_total = in_range ? slot_count[h.slot] : '0;
      e.free_total = free_count;
      expected_entries = {expected_entries, e};
    endfunction

    function void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_entry(entry_t got);
      entry_t e;
      if (expected_entries.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind %0h slot %0h",
                 $time, got.kind, got.slot);
        errors++;
        return;
      end
      e = expected_entries.pop_front();
      cmp_field("kind", 32'(e.kind), 32'(got.kind));
      cmp_field("slot_out", 32'(e.slot), 32'(got.slot));
      cmp_field("sample_rate", 32'(e.rate), 32'(got.rate));
      cmp_field("frame_count", e.frames, got.frames);
      cmp_field("slot_sector_total", 32'(e.slot_total), 32'(got.slot_total));
      cmp_field("free_total", 32'(e.free_total), 32'(got.free_total));
    endfunction

    function int unsigned pending();
      return expected_entries.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  marker_i = '0;
  logic [7:0]  slot_byte_i = '0;
  logic [7:0]  check_a_i = '0;
  logic [7:0]  check_b_i = '0;
  logic [31:0] period_raw_i = '0;
  logic [31:0] frames_raw_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  slot_out_o;
  logic [29:0] sample_rate_o;
  logic [31:0] frame_count_o;
  logic [12:0] slot_sector_total_o;
  logic [12:0] free_total_o;

  logic        hold_req = 1'b0;
  logic        quiet = 1'b0;
  int unsigned cycle_cnt = 0;

  dir_scan_scoreboard sb = new();

  sample_flash_directory_scan_top #(
    .SLOT_COUNT (SLOT_N),
    .MAX_SECTORS(MAX_SECT)
  ) i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .marker_i           (marker_i),
    .slot_byte_i        (slot_byte_i),
    .check_a_i          (check_a_i),
    .check_b_i          (check_b_i),
    .period_raw_i       (period_raw_i),
    .frames_raw_i       (frames_raw_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .kind_o             (kind_o),
    .slot_out_o         (slot_out_o),
    .sample_rate_o      (sample_rate_o),
    .frame_count_o      (frame_count_o),
    .slot_sector_total_o(slot_sector_total_o),
    .free_total_o       (free_total_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_entry('{kind: kind_e'(kind_o), slot: slot_out_o, rate: sample_rate_o,
                       frames: frame_count_o, slot_total: slot_sector_total_o,
                       free_total: free_total_o});
    end
  end

  // Result side pacing: random stall bursts, one long hold-off, none once quiet.
  initial begin : result_pacing
    bit hold_done;
    hold_done = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  task automatic send_header(input logic [7:0] marker, input logic [7:0] slot,
                             input logic [7:0] check_a, input logic [7:0] check_b,
                             input logic [31:0] period_raw, input logic [31:0] frames_raw);
    in_valid_i   <= 1'b1;
    marker_i     <= marker;
    slot_byte_i  <= slot;
    check_a_i    <= check_a;
    check_b_i    <= check_b;
    period_raw_i <= period_raw;
    frames_raw_i <= frames_raw;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_header('{marker, slot, check_a, check_b, period_raw, frames_raw});
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  initial begin : stimulus
    logic [7:0]  mk;
    logic [7:0]  sl;
    logic [7:0]  ca;
    logic [7:0]  cb;
    logic [31:0] per;
    logic [31:0] frm;
    logic [31:0] p;
    int unsigned sel;
    int unsigned n;
    logic [7:0]  tail_slot;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed headers; the period words below are given in their swapped form.
    send_header(MK_FREE, 8'hFF, 8'h00, 8'h10, 32'h0, 32'h0);
    send_header(MK_HEAD, 8'd0, HEAD_CHECK_A, HEAD_CHECK_B, 32'h0, 32'hABCD_1234);
    send_header(MK_HEAD, 8'd0, HEAD_CHECK_A, HEAD_CHECK_B, 32'h0001_0000, 32'h1);
    send_header(MK_HEAD, 8'd1, HEAD_CHECK_A, HEAD_CHECK_B, 32'h0001_0000, 32'h0);
    send_header(MK_HEAD, 8'd2, HEAD_CHECK_A, HEAD_CHECK_B, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_header(MK_HEAD, 8'd3, 8'h01, HEAD_CHECK_B, 32'h0001_0000, 32'h5);
    send_header(MK_HEAD, 8'd3, HEAD_CHECK_A, 8'h00, 32'h0001_0000, 32'h5);
    send_header(MK_HEAD, 8'd3, 8'hFF, 8'hEF, 32'h0001_0000, 32'h5);
    send_header(MK_CONT, 8'd4, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_header(MK_CONT, 8'd63, 8'h00, 8'h00, 32'h0, 32'h0);
    send_header(MK_CONT, 8'd64, 8'h00, 8'h00, 32'h0, 32'h0);
    send_header(MK_HEAD, 8'hFF, HEAD_CHECK_A, HEAD_CHECK_B, 32'h0001_0000, 32'h7);
    send_header(MK_FREE, 8'd200, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_header(8'h00, 8'd5, HEAD_CHECK_A, HEAD_CHECK_B, 32'h0001_0000, 32'h1);
    send_header(8'hFF, 8'd5, HEAD_CHECK_A, HEAD_CHECK_B, 32'h0001_0000, 32'h1);
    send_header(8'h19, 8'd5, HEAD_CHECK_A, HEAD_CHECK_B, 32'h0001_0000, 32'h1);
    send_header(MK_HEAD, 8'd63, HEAD_CHECK_A, HEAD_CHECK_B, 32'h0003_0000, 32'h0000_8000);
    // Rounding edges around a rate of one half.
    send_header(MK_HEAD, 8'd5, HEAD_CHECK_A, HEAD_CHECK_B, 32'h9400_7735, 32'h2);
    send_header(MK_HEAD, 8'd6, HEAD_CHECK_A, HEAD_CHECK_B, 32'h9401_7735, 32'h3);
    send_header(MK_HEAD, 8'd7, HEAD_CHECK_A, HEAD_CHECK_B, 32'h0002_0000, 32'h8000_0000);
    send_header(MK_CONT, 8'd0, 8'h10, 8'h00, 32'h0, 32'h0);
    send_header(MK_HEAD, 8'd62, HEAD_CHECK_A, HEAD_CHECK_B, 32'h0000_0001, 32'h1234_5678);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 200) hold_req <= 1'b1;
      if (n == 450) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (sb.pending() != 0);
      end
      sel = $urandom_range(0, 99);
      sl  = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, SLOT_N - 1))
                                       : 8'($urandom_range(SLOT_N, 255));
      ca  = 8'($urandom);
      cb  = 8'($urandom);
      per = $urandom;
      frm = $urandom;
      if (sel < 20) begin
        mk = MK_FREE;
      end else if (sel < 50) begin
        mk = MK_HEAD;
        ca = HEAD_CHECK_A;
        cb = HEAD_CHECK_B;
        case ($urandom_range(0, 5))
          0: p = 32'd0;
          1: p = $urandom_range(1, 16);
          2: p = $urandom_range(1000, 100000);
          3: p = $urandom_range(1999999990, 2000000010);
          default: p = $urandom;
        endcase
        per = {p[15:0], p[31:16]};
      end else if (sel < 78) begin
        mk = MK_CONT;
      end else if (sel < 88) begin
        // Head marker with one check byte right and the other random.
        mk = MK_HEAD;
        if ($urandom_range(0, 1) == 0) ca = HEAD_CHECK_A;
        else cb = HEAD_CHECK_B;
      end else begin
        mk = 8'($urandom);
      end
      send_header(mk, sl, ca, cb, per, frm);
    end

    // Closing run of free and continuation headers, with no idling on either side.
    quiet <= 1'b1;
    tail_slot = 8'($urandom_range(0, SLOT_N - 1));
    repeat (TAIL_PAIRS) begin
      send_header(MK_FREE, 8'($urandom), 8'($urandom), 8'($urandom), $urandom, $urandom);
      send_header(MK_CONT, tail_slot, 8'($urandom), 8'($urandom), $urandom, $urandom);
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
